// ----- hw/rtl/maxnorm_pkg.sv -----
// maxnorm_pkg: widths, constants, request codes and divider request/response types
// for the max normalising pixel converter. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package maxnorm_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 8;
  localparam int OUT_MAX    = 255;
  localparam int NUM_W      = PIXEL_BITS + OUT_W;
  localparam int CNT_W      = $clog2(OUT_W);

  // request kinds carried on in_func
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      num;
    logic [PIXEL_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/max_normalize_16_to_8.sv -----
// channel | ports                                  | direction
// in      | in_valid in_ready in_func in_pixel in_first | request in
// out     | out_valid out_ready out_scaled         | request out
//
// measure requests update the maximum and the block is ready again at once.
// convert requests run through the divider: accept, one overflow
// check, eight quotient steps, then into the output register.
// a product at or above 256 times the maximum saturates after the check.
// a zero maximum skips the divider and gives 0.
// rst_n is synchronous; it clears the maximum, the sequencers and out_valid.
// a stalled output holds its request; measure requests still flow meanwhile
// unless a second result is waiting behind it.
//
// top level of the max normaliser; uses maxnorm_pkg and maxnorm_div.
`timescale 1ns / 1ps
`default_nettype none

module max_normalize_16_to_8 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [maxnorm_pkg::IN_W-1:0]  in_pixel,
  input  wire logic                          in_first,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [maxnorm_pkg::OUT_W-1:0]      out_scaled
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t                             state_r;
  logic [maxnorm_pkg::PIXEL_BITS-1:0] max_r;
  logic [maxnorm_pkg::OUT_W-1:0]      res_r;
  logic                               out_valid_r;
  logic [maxnorm_pkg::OUT_W-1:0]      out_scaled_r;

  logic                               in_acc;
  logic                               out_free;
  logic [maxnorm_pkg::PIXEL_BITS-1:0] px;
  logic [maxnorm_pkg::PIXEL_BITS-1:0] max_nxt;
  logic                               max_zero;
  logic                               out_load;
  logic [maxnorm_pkg::OUT_W-1:0]      out_data;
  logic                               out_valid_nxt;
  maxnorm_pkg::div_req_t              div_req;
  maxnorm_pkg::div_rsp_t              div_rsp;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign px       = in_pixel[maxnorm_pkg::PIXEL_BITS-1:0];
  assign max_zero = (max_r == '0);
  assign max_nxt  = (in_first || px >= max_r) ? px : max_r;

  // pixel * 255 as (pixel << 8) - pixel
  always_comb begin
    div_req.start = in_acc & (in_func == maxnorm_pkg::FUNC_CONVERT) & ~max_zero;
    div_req.num   = maxnorm_pkg::NUM_W'({px, maxnorm_pkg::OUT_W'(0)})
                  - maxnorm_pkg::NUM_W'(px);
    div_req.den   = max_r;
  end

  maxnorm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // which result, if any, moves into the output register this cycle
  always_comb begin
    out_load = 1'b0;
    out_data = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func == maxnorm_pkg::FUNC_CONVERT && max_zero) begin
          out_load = out_free;
          out_data = '0;
        end
      end
      S_RUN: begin
        if (div_rsp.done) begin
          out_load = out_free;
          out_data = div_rsp.quot;
        end
      end
      S_WAIT: begin
        out_load = out_free;
        out_data = res_r;
      end
      default: out_load = 1'b0;
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        out_scaled_r <= out_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_func == maxnorm_pkg::FUNC_MEASURE) begin
              max_r <= max_nxt;
            end else if (max_zero) begin
              if (!out_free) begin
                res_r   <= '0;
                state_r <= S_WAIT;
              end
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (div_rsp.done) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end else begin
              res_r   <= div_rsp.quot;
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_scaled = out_scaled_r;

endmodule

`default_nettype wire

// ----- hw/rtl/maxnorm_div.sv -----
// maxnorm_div: iterative restoring divider with one shared subtractor,
// giving an 8-bit quotient saturated at full scale. uses maxnorm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module maxnorm_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire maxnorm_pkg::div_req_t req,
  output maxnorm_pkg::div_rsp_t    rsp
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHK,
    D_STEP
  } dstate_t;

  dstate_t                            state_r;
  logic [maxnorm_pkg::PIXEL_BITS-1:0] rem_r;
  logic [maxnorm_pkg::OUT_W-1:0]      low_r;
  logic [maxnorm_pkg::PIXEL_BITS-1:0] den_r;
  logic [maxnorm_pkg::CNT_W-1:0]      cnt_r;
  logic [maxnorm_pkg::OUT_W-1:0]      quot_r;
  logic                               done_r;

  logic [maxnorm_pkg::PIXEL_BITS:0]   a_op;
  logic [maxnorm_pkg::PIXEL_BITS+1:0] diff;
  logic                               ge;
  logic [maxnorm_pkg::OUT_W-1:0]      low_nxt;
  logic                               last_step;
  logic                               done_nxt;

  // shared subtractor: overflow check first, then one quotient bit a step
  always_comb begin
    if (state_r == D_CHK) begin
      a_op = {1'b0, rem_r};
    end else begin
      a_op = {rem_r, low_r[maxnorm_pkg::OUT_W-1]};
    end
    diff    = {1'b0, a_op} - {2'b00, den_r};
    ge      = ~diff[maxnorm_pkg::PIXEL_BITS+1];
    low_nxt = {low_r[maxnorm_pkg::OUT_W-2:0], ge};
  end

  assign last_step = (cnt_r == maxnorm_pkg::CNT_W'(maxnorm_pkg::OUT_W - 1));
  assign done_nxt  = ((state_r == D_CHK) & ge) | ((state_r == D_STEP) & last_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= done_nxt;
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            rem_r   <= req.num[maxnorm_pkg::NUM_W-1:maxnorm_pkg::OUT_W];
            low_r   <= req.num[maxnorm_pkg::OUT_W-1:0];
            den_r   <= req.den;
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          // upper half already at or above the divisor: quotient too big
          if (ge) begin
            quot_r  <= maxnorm_pkg::OUT_W'(maxnorm_pkg::OUT_MAX);
            state_r <= D_IDLE;
          end else begin
            cnt_r   <= '0;
            state_r <= D_STEP;
          end
        end
        D_STEP: begin
          if (ge) begin
            rem_r <= diff[maxnorm_pkg::PIXEL_BITS-1:0];
          end else begin
            rem_r <= a_op[maxnorm_pkg::PIXEL_BITS-1:0];
          end
          low_r <= low_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            quot_r  <= low_nxt;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ----- hw/rtl/maxnorm_chk.sv -----
// maxnorm_chk: port-level checks on the max normaliser, bound to the top.
// depends on maxnorm_pkg and max_normalize_16_to_8.
`timescale 1ns / 1ps
`default_nettype none

module maxnorm_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_func,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [maxnorm_pkg::OUT_W-1:0] out_scaled
);

  logic meas_acc;

  assign meas_acc = in_valid & in_ready & (in_func == maxnorm_pkg::FUNC_MEASURE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled))
    else $error("result changed while stalled");

  // after reset the block is empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // a measure request never leaves the sequencer busy
  a_meas_ready: assert property (@(posedge clk) disable iff (!rst_n)
    meas_acc |=> in_ready)
    else $error("busy after measure request");

  // a measure request never produces a result
  a_meas_nores: assert property (@(posedge clk) disable iff (!rst_n)
    meas_acc && !out_valid |=> !out_valid)
    else $error("result appeared from measure request");

endmodule

bind max_normalize_16_to_8 maxnorm_chk u_chk (.*);

`default_nettype wire

// ----- tb/sv/max_normalize_16_to_8_tb.sv -----
// max_normalize_16_to_8_tb: self-checking bench for the max normaliser. a directed table, then
// random measure/convert frames; each result checked against a local predictor or pinned byte.
// depends on maxnorm_pkg and max_normalize_16_to_8.
`timescale 1ns / 1ps

module max_normalize_16_to_8_tb;

  localparam int   RANDOM_REQUESTS = 600;
  localparam int   DRAIN_CYCLES    = 16;
  localparam int   N_DIRECTED      = 25;

  typedef struct packed {
    logic                              func;
    logic [maxnorm_pkg::IN_W-1:0]      pixel;
    logic                              first;
    logic                              pinned;
    logic [maxnorm_pkg::OUT_W-1:0]     scaled;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_func = maxnorm_pkg::FUNC_MEASURE;
  logic [maxnorm_pkg::IN_W-1:0]  in_pixel = '0;
  logic                          in_first = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [maxnorm_pkg::OUT_W-1:0] out_scaled;

  // typed-in expectation riding along with the request payload
  logic                          pinned_valid = 1'b0;
  logic [maxnorm_pkg::OUT_W-1:0] pinned_scaled = '0;

  logic [maxnorm_pkg::PIXEL_BITS-1:0] frame_max_model = '0;
  logic [maxnorm_pkg::OUT_W-1:0]      pending_scaled[$];

  int n_mismatch  = 0;
  int n_requests  = 0;
  int n_checked   = 0;
  int n_frames    = 0;
  int burst_left  = 0;

  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{maxnorm_pkg::FUNC_CONVERT, 16'd1234,  1'b0, 1'b1, 8'd0},   // convert straight after reset
    '{maxnorm_pkg::FUNC_CONVERT, 16'hFFFF,  1'b1, 1'b1, 8'd0},   // first ignored in convert pass
    '{maxnorm_pkg::FUNC_MEASURE, 16'h0000,  1'b1, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'hFFFF,  1'b0, 1'b1, 8'd0},   // zero maximum
    '{maxnorm_pkg::FUNC_MEASURE, 16'hFFFF,  1'b1, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'hFFFF,  1'b0, 1'b1, 8'd255},
    '{maxnorm_pkg::FUNC_CONVERT, 16'h0000,  1'b0, 1'b1, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'h8000,  1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'd100,   1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'd1,     1'b1, 1'b0, 8'd0},   // restart drops the maximum
    '{maxnorm_pkg::FUNC_MEASURE, 16'd0,     1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'd1,     1'b0, 1'b1, 8'd255},
    '{maxnorm_pkg::FUNC_CONVERT, 16'd2,     1'b0, 1'b1, 8'd255}, // above maximum saturates
    '{maxnorm_pkg::FUNC_CONVERT, 16'hFFFF,  1'b0, 1'b1, 8'd255},
    '{maxnorm_pkg::FUNC_CONVERT, 16'h0000,  1'b0, 1'b1, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'd1000,  1'b1, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'd999,   1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'd1000,  1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'd999,   1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'd1001,  1'b0, 1'b1, 8'd255},
    '{maxnorm_pkg::FUNC_CONVERT, 16'd1234,  1'b1, 1'b1, 8'd255},
    '{maxnorm_pkg::FUNC_MEASURE, 16'hAAAA,  1'b1, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'h5555,  1'b0, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_MEASURE, 16'h0000,  1'b1, 1'b0, 8'd0},
    '{maxnorm_pkg::FUNC_CONVERT, 16'h5555,  1'b0, 1'b1, 8'd0}
  };

  max_normalize_16_to_8 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_pixel   (in_pixel),
    .in_first   (in_first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_scaled (out_scaled)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [maxnorm_pkg::OUT_W-1:0] scale_to_byte(
      input logic [maxnorm_pkg::PIXEL_BITS-1:0] px,
      input logic [maxnorm_pkg::PIXEL_BITS-1:0] mx);
    logic [maxnorm_pkg::NUM_W-1:0] quot;
    if (mx == '0) return '0;
    quot = (maxnorm_pkg::NUM_W'(px) * maxnorm_pkg::NUM_W'(maxnorm_pkg::OUT_MAX))
         / maxnorm_pkg::NUM_W'(mx);
    if (quot > maxnorm_pkg::NUM_W'(maxnorm_pkg::OUT_MAX))
      return maxnorm_pkg::OUT_W'(maxnorm_pkg::OUT_MAX);
    return quot[maxnorm_pkg::OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin : scoreboard
    logic [maxnorm_pkg::PIXEL_BITS-1:0] px;
    logic [maxnorm_pkg::PIXEL_BITS-1:0] run_max;
    logic [maxnorm_pkg::OUT_W-1:0]      want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        px = in_pixel[maxnorm_pkg::PIXEL_BITS-1:0];
        if (in_func == maxnorm_pkg::FUNC_CONVERT) begin
          want = pinned_valid ? pinned_scaled : scale_to_byte(px, frame_max_model);
          pending_scaled.push_back(want);
        end else begin
          run_max = in_first ? '0 : frame_max_model;
          frame_max_model <= (px >= run_max) ? px : run_max;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_scaled.size() == 0) begin
          report_mismatch($sformatf("scaled pixel %0d with nothing pending", out_scaled));
        end else begin
          want = pending_scaled.pop_front();
          n_checked++;
          if (out_scaled !== want)
            report_mismatch($sformatf("scaled got %0d want %0d", out_scaled, want));
        end
      end
    end
  end

  // receiver stall pattern: always ready, coin toss, or mostly stalled
  always @(posedge clk) begin : receiver
    int unsigned mode_cycles;
    int unsigned mode;
    if (mode_cycles == 0) begin
      mode = $urandom_range(0, 2);
      mode_cycles = $urandom_range(16, 96);
    end else begin
      mode_cycles--;
    end
    case (mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // sender bursts with random gaps, sometimes long stretches with none
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  task automatic send_request(input logic func, input logic [maxnorm_pkg::IN_W-1:0] pixel,
                              input logic first_flag, input logic pin,
                              input logic [maxnorm_pkg::OUT_W-1:0] pin_val);
    in_valid      <= 1'b1;
    in_func       <= func;
    in_pixel      <= pixel;
    in_first      <= first_flag;
    pinned_valid  <= pin;
    pinned_scaled <= pin_val;
    do @(posedge clk); while (!(in_valid && in_ready));
    n_requests++;
    pace();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_scaled.size() != 0) @(posedge clk);
  endtask

  function automatic logic [maxnorm_pkg::IN_W-1:0] pick_pixel(input int w);
    logic [maxnorm_pkg::IN_W-1:0] mask;
    mask = maxnorm_pkg::IN_W'((32'd1 << w) - 1);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return mask;
      default: return maxnorm_pkg::IN_W'($urandom) & mask;
    endcase
  endfunction

  initial begin : stimulus
    int sent_random;
    int w;
    int n_meas;
    int n_conv;
    int n_noise;
    bit paused;
    logic [maxnorm_pkg::IN_W-1:0] px;
    sent_random = 0;
    paused = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].func, directed_rows[i].pixel, directed_rows[i].first,
                   directed_rows[i].pinned, directed_rows[i].scaled);
    wait_for_drain();

    while (sent_random < RANDOM_REQUESTS) begin
      if (!paused && sent_random >= RANDOM_REQUESTS / 2) begin
        wait_for_drain();
        paused = 1;
      end
      if ($urandom_range(0, 99) < 85) begin
        // well-formed frame: measure pass then convert pass over a random range
        w = $urandom_range(1, 16);
        n_meas = $urandom_range(1, 10);
        n_conv = $urandom_range(1, 12);
        for (int i = 0; i < n_meas; i++)
          send_request(maxnorm_pkg::FUNC_MEASURE, pick_pixel(w),
                       (i == 0) && ($urandom_range(0, 9) != 0), 1'b0, '0);
        for (int j = 0; j < n_conv; j++) begin
          px = ($urandom_range(0, 9) == 0) ? maxnorm_pkg::IN_W'($urandom) : pick_pixel(w);
          send_request(maxnorm_pkg::FUNC_CONVERT, px, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        sent_random += n_meas + n_conv;
        n_frames++;
      end else begin
        n_noise = $urandom_range(1, 4);
        for (int k = 0; k < n_noise; k++)
          send_request(1'($urandom_range(0, 1)), maxnorm_pkg::IN_W'($urandom),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        sent_random += n_noise;
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_scaled.size() != 0)
      report_mismatch($sformatf("%0d scaled pixels never arrived", pending_scaled.size()));

    $display("%0d requests in %0d random frames plus directed table", n_requests, n_frames);
    $display("%0d scaled pixels checked, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- max_normalize_16_to_8.f -----
hw/rtl/maxnorm_pkg.sv
hw/rtl/maxnorm_div.sv
hw/rtl/max_normalize_16_to_8.sv
hw/rtl/maxnorm_chk.sv
tb/sv/max_normalize_16_to_8_tb.sv
